// ----- design/base64_stream_encoder_top_assert.svh -----
// ----------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Concurrent assertion forms, used by the character sequencer module.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_TOP_ASSERT_SVH
`define BASE64_STREAM_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define B64E_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while out of reset.
`define B64E_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/b64e_pkg.sv -----
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Transaction types, character codes and the alphabet mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       final_char;
   } rsp_type;

   typedef struct packed {
      logic url_alphabet;
      logic percent_escape;
   } cfg_type;

   // One completed group: up to four characters, how many are sent, last mark.
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [2:0]      count;
      logic            final_group;
   } group_type;

   // Register indexes, selected by the word address bit.
   localparam logic REG_URL_ALPHABET   = 1'b0;
   localparam logic REG_PERCENT_ESCAPE = 1'b1;

   localparam logic [5:0] IDX_MASK = 6'h3f;

   localparam logic [7:0] CHAR_PAD     = 8'h3D; // '='
   localparam logic [7:0] CHAR_PLUS    = 8'h2B; // '+'
   localparam logic [7:0] CHAR_SLASH   = 8'h2F; // '/'
   localparam logic [7:0] CHAR_MINUS   = 8'h2D; // '-'
   localparam logic [7:0] CHAR_UNDER   = 8'h5F; // '_'
   localparam logic [7:0] CHAR_PERCENT = 8'h25; // '%'
   localparam logic [7:0] CHAR_TWO     = 8'h32; // '2'
   localparam logic [7:0] CHAR_THREE   = 8'h33; // '3'
   localparam logic [7:0] CHAR_UPPER_B = 8'h42; // 'B'
   localparam logic [7:0] CHAR_UPPER_F = 8'h46; // 'F'
   localparam logic [7:0] CHAR_UPPER_D = 8'h44; // 'D'
   localparam logic [7:0] CHAR_UPPER_A = 8'h41; // 'A'
   localparam logic [7:0] CHAR_LOWER_A = 8'h61; // 'a'
   localparam logic [7:0] CHAR_ZERO    = 8'h30; // '0'

   // Six-bit index to its alphabet character.
   function automatic logic [7:0] index_to_char(logic [5:0] idx, logic url);
      logic [7:0] ch;
      logic [7:0] wide;
      wide = {2'b00, idx & IDX_MASK};
      if (idx < 6'd26) begin
         ch = wide + CHAR_UPPER_A;
      end else if (idx < 6'd52) begin
         ch = wide + (CHAR_LOWER_A - 8'd26);
      end else if (idx < 6'd62) begin
         ch = wide + (CHAR_ZERO - 8'd52);
      end else if (idx == 6'd62) begin
         ch = url ? CHAR_MINUS : CHAR_PLUS;
      end else begin
         ch = url ? CHAR_UNDER : CHAR_SLASH;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

// ----- design/b64e_csr.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder control registers
// APB-style register port holding the alphabet and escape mode bits.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic      [31:0]      prdata,
   output logic                  pready,
   output b64e_pkg::cfg_type     cfg
);

   b64e_pkg::cfg_type cfg_ff;
   b64e_pkg::cfg_type cfg_in;
   logic              write_en;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (paddr[2])
            b64e_pkg::REG_URL_ALPHABET:   cfg_in.url_alphabet   = pwdata[0];
            b64e_pkg::REG_PERCENT_ESCAPE: cfg_in.percent_escape = pwdata[0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[2])
         b64e_pkg::REG_URL_ALPHABET:   prdata = {31'd0, cfg_ff.url_alphabet};
         b64e_pkg::REG_PERCENT_ESCAPE: prdata = {31'd0, cfg_ff.percent_escape};
         default:                      prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- design/b64e_group.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder group builder
// Holds up to two bytes and turns each completed group into characters.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_group (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire b64e_pkg::cfg_type   cfg,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire b64e_pkg::req_type   req_payload,
   input  wire logic                grp_take,
   output logic                     grp_valid,
   output b64e_pkg::group_type      grp
);

   logic [7:0]          held0_ff, held0_in;
   logic [7:0]          held1_ff, held1_in;
   logic [1:0]          held_cnt_ff, held_cnt_in;
   logic                grp_valid_ff, grp_valid_in;
   b64e_pkg::group_type grp_ff, grp_in;

   logic [1:0] cnt;
   logic       completing;
   logic       accept;
   logic       pad;
   logic [7:0] b1, b2, b3;
   logic [5:0] idx0, idx1, idx2, idx3;

   // A count above two never occurs; it is treated as two.
   assign cnt        = (held_cnt_ff > 2'd2) ? 2'd2 : held_cnt_ff;
   assign completing = req_payload.final_byte || (cnt == 2'd2);
   assign req_stall  = completing && grp_valid_ff && !grp_take;
   assign accept     = req_valid && !req_stall;
   assign pad        = cfg.percent_escape || !cfg.url_alphabet;

   always_comb begin
      b1 = (cnt == 2'd0) ? req_payload.data_byte : held0_ff;
      b2 = (cnt == 2'd1) ? req_payload.data_byte : ((cnt == 2'd2) ? held1_ff : 8'd0);
      b3 = (cnt == 2'd2) ? req_payload.data_byte : 8'd0;
      idx0 = b1[7:2];
      idx1 = {b1[1:0], b2[7:4]};
      idx2 = {b2[3:0], b3[7:6]};
      idx3 = b3[5:0];
   end

   always_comb begin
      held0_in     = held0_ff;
      held1_in     = held1_ff;
      held_cnt_in  = held_cnt_ff;
      grp_valid_in = grp_valid_ff && !grp_take;
      grp_in       = grp_ff;
      if (accept && !completing) begin
         if (cnt == 2'd0) begin
            held0_in = req_payload.data_byte;
         end else begin
            held1_in = req_payload.data_byte;
         end
         held_cnt_in = cnt + 2'd1;
      end else if (accept) begin
         held0_in     = 8'd0;
         held1_in     = 8'd0;
         held_cnt_in  = 2'd0;
         grp_valid_in = 1'b1;
         grp_in.chars[0] = b64e_pkg::index_to_char(idx0, cfg.url_alphabet);
         grp_in.chars[1] = b64e_pkg::index_to_char(idx1, cfg.url_alphabet);
         grp_in.chars[2] = (cnt != 2'd0) ?
            b64e_pkg::index_to_char(idx2, cfg.url_alphabet) : b64e_pkg::CHAR_PAD;
         grp_in.chars[3] = (cnt == 2'd2) ?
            b64e_pkg::index_to_char(idx3, cfg.url_alphabet) : b64e_pkg::CHAR_PAD;
         // Without padding a short group sends one character more than its bytes.
         if (cnt == 2'd2 || pad) begin
            grp_in.count = 3'd4;
         end else begin
            grp_in.count = {1'b0, cnt} + 3'd2;
         end
         grp_in.final_group = req_payload.final_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held0_ff     <= 8'd0;
         held1_ff     <= 8'd0;
         held_cnt_ff  <= 2'd0;
         grp_valid_ff <= 1'b0;
      end else begin
         held0_ff     <= held0_in;
         held1_ff     <= held1_in;
         held_cnt_ff  <= held_cnt_in;
         grp_valid_ff <= grp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   assign grp_valid = grp_valid_ff;
   assign grp       = grp_ff;

endmodule

`default_nettype wire

// ----- design/b64e_emit.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder character sequencer
// Sends a group's characters one per cycle while rsp is not stalled, expanding percent escapes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "base64_stream_encoder_top_assert.svh"

module b64e_emit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire b64e_pkg::cfg_type     cfg,
   input  wire logic                  grp_valid,
   input  wire b64e_pkg::group_type   grp,
   output logic                       grp_take,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output b64e_pkg::rsp_type          rsp_payload
);

   logic [1:0]        sym_ff, sym_in;
   logic [1:0]        sub_ff, sub_in;
   logic              rsp_valid_ff, rsp_valid_in;
   b64e_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic       load;
   logic       fire;
   logic [7:0] ch;
   logic       esc_hit;
   logic [7:0] esc_second;
   logic [7:0] esc_third;
   logic [7:0] out_ch;
   logic       char_done;
   logic       grp_done;

   assign load    = !rsp_valid_ff || !rsp_stall;
   assign fire    = load && grp_valid;
   assign ch      = grp.chars[sym_ff];
   assign esc_hit = cfg.percent_escape &&
                    (ch == b64e_pkg::CHAR_PLUS || ch == b64e_pkg::CHAR_SLASH ||
                     ch == b64e_pkg::CHAR_PAD);

   always_comb begin
      esc_second = (ch == b64e_pkg::CHAR_PAD) ? b64e_pkg::CHAR_THREE : b64e_pkg::CHAR_TWO;
      if (ch == b64e_pkg::CHAR_PLUS) begin
         esc_third = b64e_pkg::CHAR_UPPER_B;
      end else if (ch == b64e_pkg::CHAR_SLASH) begin
         esc_third = b64e_pkg::CHAR_UPPER_F;
      end else begin
         esc_third = b64e_pkg::CHAR_UPPER_D;
      end
      if (!esc_hit) begin
         out_ch = ch;
      end else begin
         case (sub_ff)
            2'd0:    out_ch = b64e_pkg::CHAR_PERCENT;
            2'd1:    out_ch = esc_second;
            default: out_ch = esc_third;
         endcase
      end
   end

   assign char_done = !esc_hit || (sub_ff == 2'd2);
   assign grp_done  = char_done && (({1'b0, sym_ff} + 3'd1) == grp.count);
   assign grp_take  = fire && grp_done;

   always_comb begin
      sym_in         = sym_ff;
      sub_in         = sub_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         rsp_valid_in = fire;
      end
      if (fire) begin
         rsp_payload_in.out_char   = out_ch;
         rsp_payload_in.final_char = grp.final_group && grp_done;
         if (grp_done) begin
            sym_in = 2'd0;
            sub_in = 2'd0;
         end else if (char_done) begin
            sym_in = sym_ff + 2'd1;
            sub_in = 2'd0;
         end else begin
            sub_in = sub_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff       <= 2'd0;
         sub_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sym_ff       <= sym_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `B64E_ASSERT_SAME(a_sub_in_range, clock, reset, 1'b1, sub_ff != 2'd3, "escape step out of range")
   `B64E_ASSERT_SAME(a_mid_escape_has_group, clock, reset, sub_ff != 2'd0, grp_valid, "escape without group")
   `B64E_ASSERT_SAME(a_mid_group_has_group, clock, reset, sym_ff != 2'd0, grp_valid, "position without group")
   `B64E_ASSERT_NEXT(a_final_marked, clock, reset, grp_take && grp.final_group, rsp_valid && rsp_payload.final_char, "last character not marked")

endmodule

`default_nettype wire

// ----- design/base64_stream_encoder_top.sv -----
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Byte stream in, Base64 text out one character per transaction.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  req       in         req_valid/req_stall  data_byte, final_byte
//  rsp       out        rsp_valid/rsp_stall  out_char, final_char
//  csr       in         APB psel/penable     url_alphabet (0x0), percent_escape (0x4)
//
// One character leaves per cycle from the character sequencer unless rsp is
// stalled; a completed group gives 2 to 4 characters, or up to 12 with percent
// escapes. A byte that only gets held is never stalled; a group-completing byte
// waits while the group register is still being sent. Synchronous reset clears
// the held count, the group and output valid bits and both mode registers. A
// stall on rsp holds the output register and backs up into req only at the next
// group-completing byte.
`default_nettype none

module base64_stream_encoder_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire b64e_pkg::req_type   req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output b64e_pkg::rsp_type        rsp_payload,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic      [31:0]         prdata,
   output logic                     pready
);

   b64e_pkg::cfg_type   cfg;
   logic                grp_valid;
   logic                grp_take;
   b64e_pkg::group_type grp;

   b64e_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   b64e_group u_group (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .grp_take    (grp_take),
      .grp_valid   (grp_valid),
      .grp         (grp)
   );

   b64e_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .grp_valid   (grp_valid),
      .grp         (grp),
      .grp_take    (grp_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
